@@ hw/rtl/tun_pkg.sv @@
package tun_pkg;

    localparam int IN_W  = 16;
    localparam int D_W   = 17;
    localparam int V_W   = 35;
    localparam int C_W   = 34;
    localparam int H_W   = 17;
    localparam int SQ_W  = 68;
    localparam int R_W   = 98;
    localparam int P_W   = 84;
    localparam int Q_W   = 15;
    localparam int FRAC  = 28;
    localparam int OUT_W = 16;

    localparam logic KIND_VERTS  = 1'b0;
    localparam logic KIND_VECTOR = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [IN_W-1:0]  ax;
        logic signed [IN_W-1:0]  ay;
        logic signed [IN_W-1:0]  az;
        logic signed [IN_W-1:0]  bx;
        logic signed [IN_W-1:0]  by_coord;
        logic signed [IN_W-1:0]  bz;
        logic signed [IN_W-1:0]  cx;
        logic signed [IN_W-1:0]  cy;
        logic signed [IN_W-1:0]  cz;
    } tun_req_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] nx;
        logic signed [OUT_W-1:0] ny;
        logic signed [OUT_W-1:0] nz;
        logic                    degenerate;
    } tun_rsp_t;

    // two's complement vector components, x in lane 0
    typedef logic [2:0][V_W-1:0] tun_vec_t;

    typedef struct packed {
        logic [SQ_W-1:0]       s;
        logic [2:0][R_W-1:0]   r;
        logic [2:0][P_W-1:0]   p;
        logic [2:0][Q_W-1:0]   q;
        logic [2:0]            neg;
        logic                  zero;
    } tun_iter_t;

endpackage

@@ hw/rtl/tun_cross.sv @@
module tun_cross
    import tun_pkg::*;
(
    input  logic      clk,
    input  logic [2:0] adv,
    input  tun_req_t  req,
    output tun_vec_t  vec
);

    logic                   kind1_reg;
    logic signed [IN_W-1:0] a1_reg [3];
    logic signed [D_W-1:0]  e_reg  [3];
    logic signed [D_W-1:0]  f_reg  [3];

    logic                   kind2_reg;
    logic signed [IN_W-1:0] a2_reg [3];
    logic signed [C_W-1:0]  p_reg  [6];

    tun_vec_t               vec_reg;

    // stage 1: edge vectors
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            kind1_reg <= req.kind;
            a1_reg[0] <= req.ax;
            a1_reg[1] <= req.ay;
            a1_reg[2] <= req.az;
            e_reg[0]  <= D_W'(req.bx) - D_W'(req.ax);
            e_reg[1]  <= D_W'(req.by_coord) - D_W'(req.ay);
            e_reg[2]  <= D_W'(req.bz) - D_W'(req.az);
            f_reg[0]  <= D_W'(req.cx) - D_W'(req.ax);
            f_reg[1]  <= D_W'(req.cy) - D_W'(req.ay);
            f_reg[2]  <= D_W'(req.cz) - D_W'(req.az);
        end
    end

    // stage 2: cross product terms
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            kind2_reg <= kind1_reg;
            a2_reg    <= a1_reg;
            p_reg[0]  <= e_reg[1] * f_reg[2];
            p_reg[1]  <= e_reg[2] * f_reg[1];
            p_reg[2]  <= e_reg[2] * f_reg[0];
            p_reg[3]  <= e_reg[0] * f_reg[2];
            p_reg[4]  <= e_reg[0] * f_reg[1];
            p_reg[5]  <= e_reg[1] * f_reg[0];
        end
    end

    // stage 3: cross product, or pass the given vector
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (kind2_reg == KIND_VECTOR)
                    vec_reg[i] <= V_W'(a2_reg[i]);
                else
                    vec_reg[i] <= V_W'(p_reg[2*i]) - V_W'(p_reg[2*i+1]);
            end
        end
    end

    assign vec = vec_reg;

endmodule

@@ hw/rtl/tun_square.sv @@
module tun_square
    import tun_pkg::*;
(
    input  logic       clk,
    input  logic [3:0] adv,
    input  tun_vec_t   vec,
    output tun_iter_t  iter
);

    logic [2:0][C_W-1:0]  mag_next;
    logic [2:0][C_W-1:0]  mag_reg;
    logic [2:0]           neg4_reg;
    logic                 zero4_reg;

    logic [2:0][C_W-1:0]  hh_reg;
    logic [2:0][C_W-1:0]  hl_reg;
    logic [2:0][C_W-1:0]  ll_reg;
    logic [2:0]           neg5_reg;
    logic                 zero5_reg;

    logic [2:0][SQ_W-1:0] sq_reg;
    logic [2:0]           neg6_reg;
    logic                 zero6_reg;

    tun_iter_t            iter_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (vec[i][V_W-1])
                mag_next[i] = C_W'(-vec[i]);
            else
                mag_next[i] = C_W'(vec[i]);
        end
    end

    // stage 4: magnitudes
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            mag_reg   <= mag_next;
            for (int i = 0; i < 3; i++)
                neg4_reg[i] <= vec[i][V_W-1];
            zero4_reg <= (vec == '0);
        end
    end

    // stage 5: partial squares on 17-bit halves
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                hh_reg[i] <= C_W'(mag_reg[i][C_W-1:H_W]) * C_W'(mag_reg[i][C_W-1:H_W]);
                hl_reg[i] <= C_W'(mag_reg[i][C_W-1:H_W]) * C_W'(mag_reg[i][H_W-1:0]);
                ll_reg[i] <= C_W'(mag_reg[i][H_W-1:0]) * C_W'(mag_reg[i][H_W-1:0]);
            end
            neg5_reg  <= neg4_reg;
            zero5_reg <= zero4_reg;
        end
    end

    // stage 6: full squares
    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= (SQ_W'(hh_reg[i]) << (2*H_W))
                           + (SQ_W'(hl_reg[i]) << (H_W+1))
                           + SQ_W'(ll_reg[i]);
            neg6_reg  <= neg5_reg;
            zero6_reg <= zero5_reg;
        end
    end

    // stage 7: squared length and initial remainders
    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            iter_reg.s <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                iter_reg.r[i] <= R_W'(sq_reg[i]) << FRAC;
                iter_reg.p[i] <= '0;
                iter_reg.q[i] <= '0;
            end
            iter_reg.neg  <= neg6_reg;
            iter_reg.zero <= zero6_reg;
        end
    end

    assign iter = iter_reg;

endmodule

@@ hw/rtl/tun_step.sv @@
module tun_step
    import tun_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic      clk,
    input  logic      en,
    input  tun_iter_t cur,
    output tun_iter_t nxt
);

    logic [2:0][R_W-1:0] term;
    logic [2:0][R_W:0]   diff;
    tun_iter_t           nxt_next;
    tun_iter_t           nxt_reg;

    // test q + 2^BIT: (q + 2^BIT)^2 * s = q^2 * s + 2^(BIT+1) * p + 2^(2*BIT) * s
    always_comb
    begin
        nxt_next = cur;
        for (int i = 0; i < 3; i++)
        begin
            term[i] = (R_W'(cur.p[i]) << (BIT+1)) + (R_W'(cur.s) << (2*BIT));
            diff[i] = {1'b0, cur.r[i]} - {1'b0, term[i]};
            if (!diff[i][R_W])
            begin
                nxt_next.r[i] = diff[i][R_W-1:0];
                nxt_next.p[i] = cur.p[i] + (P_W'(cur.s) << BIT);
                nxt_next.q[i] = cur.q[i] | (Q_W'(1) << BIT);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            nxt_reg <= nxt_next;
    end

    assign nxt = nxt_reg;

endmodule

@@ hw/rtl/triangle_unit_normal.sv @@
// Unit normal of a triangle, or of a given vector, in signed Q1.14.
// Request channel (req_valid/req_ready/req): kind 0 takes vertices a, b, c
// and uses the cross product of (b - a) and (c - a); kind 1 normalizes the
// vector carried in a. Coordinates are signed Q8.8.
// Response channel (rsp_valid/rsp_ready/rsp): nx, ny, nz truncated toward
// zero, plus degenerate, set with a zero normal when the vector is zero.
// From request accept to response valid, the request
// passes 23 register stages, the first loaded at the accept edge: 3 of
// cross product, 4 of magnitude and squared length, 15 of bit-serial
// normalization (one quotient bit per stage), 1 output register.
// One request per cycle while rsp_ready stays high; every stage is a
// pipeline register and normalization unrolls to a restoring step each.
// Reset clears all stage valid bits; no request is in flight afterward.
// When the receiver holds rsp_ready low, the output stage holds its
// response and stages behind it keep advancing into empty slots, so
// req_ready drops only once every stage is occupied.
module triangle_unit_normal
    import tun_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  tun_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output tun_rsp_t rsp
);

    localparam int NSTEP  = Q_W;
    localparam int NSTAGE = 7 + NSTEP + 1;
    localparam int OUT_ST = NSTAGE - 1;

    logic [NSTAGE-1:0] valid_reg;
    logic [NSTAGE-1:0] valid_next;
    logic [NSTAGE:0]   adv;

    tun_vec_t          vec;
    tun_iter_t         iter_w [NSTEP+1];
    tun_iter_t         fin;
    tun_rsp_t          rsp_next;
    tun_rsp_t          rsp_reg;
    logic [2:0][OUT_W-1:0] comp;

    // a stage advances when empty or when the one ahead advances
    always_comb
    begin
        adv[NSTAGE] = rsp_ready;
        for (int k = NSTAGE-1; k >= 0; k--)
            adv[k] = !valid_reg[k] || adv[k+1];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[0])
            valid_next[0] = req_valid;
        for (int k = 1; k < NSTAGE; k++)
        begin
            if (adv[k])
                valid_next[k] = valid_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    tun_cross u_cross (
        .clk (clk),
        .adv (adv[2:0]),
        .req (req),
        .vec (vec)
    );

    tun_square u_square (
        .clk  (clk),
        .adv  (adv[6:3]),
        .vec  (vec),
        .iter (iter_w[0])
    );

    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        tun_step #(.BIT(NSTEP-1-j)) u_step (
            .clk (clk),
            .en  (adv[7+j]),
            .cur (iter_w[j]),
            .nxt (iter_w[j+1])
        );
    end

    assign fin = iter_w[NSTEP];

    // apply signs; zero vector gives a zero normal
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (fin.zero)
                comp[i] = '0;
            else if (fin.neg[i])
                comp[i] = -OUT_W'(fin.q[i]);
            else
                comp[i] = OUT_W'(fin.q[i]);
        end
        rsp_next.nx         = comp[0];
        rsp_next.ny         = comp[1];
        rsp_next.nz         = comp[2];
        rsp_next.degenerate = fin.zero;
    end

    always_ff @(posedge clk)
    begin
        if (adv[OUT_ST])
            rsp_reg <= rsp_next;
    end

    assign req_ready = adv[0];
    assign rsp_valid = valid_reg[OUT_ST];
    assign rsp       = rsp_reg;

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.degenerate |->
            rsp.nx <= 16'sd16384 && rsp.nx >= -16'sd16384 &&
            rsp.ny <= 16'sd16384 && rsp.ny >= -16'sd16384 &&
            rsp.nz <= 16'sd16384 && rsp.nz >= -16'sd16384)
        else $error("normal component out of unit range");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.degenerate |-> rsp.nx == '0 && rsp.ny == '0 && rsp.nz == '0)
        else $error("degenerate response with nonzero normal");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> valid_reg[0])
        else $error("accepted request not captured");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reg))
        else $error("stalled response changed");

endmodule
